/* hdl/lss_pkg.sv */
package lss_pkg;

   localparam int unsigned WORD_W = 32;

   typedef enum logic [1:0] {
      MODE_PUSH   = 2'd0,
      MODE_POP    = 2'd1,
      MODE_DUMP   = 2'd2,
      MODE_SEARCH = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_EMPTY    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_DUMP,
      S_SEARCH
   } state_type;

endpackage

/* hdl/lss_ram.sv */
module lss_ram
   import lss_pkg::*;
#(
   parameter int unsigned DEPTH  = 8,
   parameter int unsigned ADDR_W = 3
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/lifo_stack_with_search.sv */
// Latency: push, and any operation on an empty stack, answers in the cycle after start.
// Pop data goes via the RAM read and output registers; dump gives one beat a cycle.
// Search walks one entry a cycle from the top, one port read each, to a hit or the bottom.
// Throughput: push and empty-stack answers one per cycle; others hold busy to the last beat.
// Reset (synchronous, active high) empties the stack; stored words are not cleared.
module lifo_stack_with_search
   import lss_pkg::*;
#(
   parameter int unsigned DEPTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_value,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_data,
   output logic               rsp_found,
   output logic               rsp_last
);

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic [WORD_W-1:0] value_ff, value_in;

   logic              strobe_ff, strobe_in;
   status_type        status_ff, status_in;
   logic [WORD_W-1:0] data_ff, data_in;
   logic              found_ff, found_in;
   logic              last_ff, last_in;

   logic              wr_en, rd_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic [WORD_W-1:0] wr_data, rd_data;

   logic              accept, empty, full, hit;
   logic [IDX_W-1:0]  top_idx;
   mode_type          mode;

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign mode    = mode_type'(req_mode);
   assign empty   = (fill_ff == '0);
   assign full    = (fill_ff == CNT_W'(DEPTH));
   assign top_idx = IDX_W'(fill_ff - 1'b1);
   assign hit     = (rd_data == value_ff);

   lss_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && !empty) begin
               case (mode)
                  MODE_POP:    state_in = S_POP;
                  MODE_DUMP:   state_in = S_DUMP;
                  MODE_SEARCH: state_in = S_SEARCH;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_POP: begin
            state_in = S_IDLE;
         end
         S_DUMP: begin
            if (ptr_ff == '0) begin
               state_in = S_IDLE;
            end
         end
         S_SEARCH: begin
            if (hit || ptr_ff == '0) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      strobe_in = 1'b0;
      status_in = ST_OK;
      data_in   = '0;
      found_in  = 1'b0;
      last_in   = 1'b1;
      fill_in   = fill_ff;
      ptr_in    = ptr_ff;
      value_in  = value_ff;
      wr_en     = 1'b0;
      wr_addr   = IDX_W'(fill_ff);
      wr_data   = req_value;
      rd_en     = 1'b0;
      rd_addr   = ptr_ff - 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               value_in = req_value;
               ptr_in   = top_idx;
               rd_addr  = top_idx;
               if (mode == MODE_PUSH) begin
                  strobe_in = 1'b1;
                  if (full) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     wr_en   = 1'b1;
                     fill_in = fill_ff + 1'b1;
                  end
               end else if (empty) begin
                  strobe_in = 1'b1;
                  status_in = ST_EMPTY;
               end else begin
                  rd_en = 1'b1;
                  if (mode == MODE_POP) begin
                     fill_in = fill_ff - 1'b1;
                  end
               end
            end
         end
         S_POP: begin
            strobe_in = 1'b1;
            data_in   = rd_data;
         end
         S_DUMP: begin
            strobe_in = 1'b1;
            data_in   = rd_data;
            last_in   = (ptr_ff == '0);
            if (ptr_ff != '0) begin
               rd_en  = 1'b1;
               ptr_in = ptr_ff - 1'b1;
            end
         end
         S_SEARCH: begin
            if (hit || ptr_ff == '0) begin
               strobe_in = 1'b1;
               found_in  = hit;
            end else begin
               rd_en  = 1'b1;
               ptr_in = ptr_ff - 1'b1;
            end
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fill_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      data_ff   <= data_in;
      found_ff  <= found_in;
      last_ff   <= last_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign rsp_data   = data_ff;
   assign rsp_found  = found_ff;
   assign rsp_last   = last_ff;

endmodule

/* hdl/lss_checker.sv */
module lss_checker
   import lss_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic [1:0]         rsp_status,
   input logic signed [31:0] rsp_data,
   input logic               rsp_found,
   input logic               rsp_last
);

   // every accepted command either answers next cycle or goes busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_strobe || busy)
      else $error("accepted command neither answered nor busy");

   // final beat releases the block
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> !busy)
      else $error("busy after final beat");

   // only a dump gives unmarked beats, and it keeps going
   a_more_beats: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> busy && rsp_status == ST_OK && !rsp_found)
      else $error("bad intermediate beat");

   a_error_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_OK |-> rsp_last && rsp_data == 0 && !rsp_found)
      else $error("malformed error beat");

endmodule

bind lifo_stack_with_search lss_checker u_lss_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_status (rsp_status),
   .rsp_data   (rsp_data),
   .rsp_found  (rsp_found),
   .rsp_last   (rsp_last)
);

/* verif/tb_lifo_stack_with_search.sv */
`timescale 1ns / 1ps
module tb_lifo_stack_with_search;
   import lss_pkg::*;

   localparam int DEPTH      = 8;
   localparam int N_RANDOM   = 430;
   localparam int IDLE_LIMIT = 200;
   localparam int TAIL       = 12;

   typedef struct {
      status_type         status;
      logic signed [31:0] data;
      logic               found;
      logic               last;
   } beat_type;

   typedef struct {
      mode_type           mode;
      logic signed [31:0] value;
      bit                 pin;
      status_type         status;
      logic signed [31:0] data;
   } row_type;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               start     = 1'b0;
   logic               busy;
   logic [1:0]         req_mode  = MODE_PUSH;
   logic signed [31:0] req_value = '0;
   logic               rsp_strobe;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_data;
   logic               rsp_found;
   logic               rsp_last;

   // typed-in answer travelling alongside the request beat
   bit                 pin_valid  = 1'b0;
   status_type         pin_status = ST_OK;
   logic signed [31:0] pin_data   = '0;

   lifo_stack_with_search #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_mode   (req_mode),
      .req_value  (req_value),
      .rsp_strobe (rsp_strobe),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_found  (rsp_found),
      .rsp_last   (rsp_last)
   );

   always #10 clock = ~clock;

   logic signed [31:0] stack_words [DEPTH];
   int                 stack_fill     = 0;
   beat_type           pending_beats [$];
   int                 errors         = 0;
   int                 idle_cycles    = 0;
   int                 beats_seen     = 0;
   int                 mode_count [4] = '{0, 0, 0, 0};
   int                 overflow_count = 0;
   int                 empty_count    = 0;
   int                 peak_fill      = 0;
   int                 no_gap_run     = 0;

   row_type directed [24] = '{
      '{MODE_POP,    32'sd0,            1'b1, ST_EMPTY,    32'sd0},
      '{MODE_DUMP,   32'sd0,            1'b1, ST_EMPTY,    32'sd0},
      '{MODE_SEARCH, 32'sd0,            1'b1, ST_EMPTY,    32'sd0},
      '{MODE_PUSH,   32'sh8000_0000,    1'b1, ST_OK,       32'sd0},
      '{MODE_PUSH,   32'sh7fff_ffff,    1'b1, ST_OK,       32'sd0},
      '{MODE_SEARCH, 32'sh8000_0000,    1'b0, ST_OK,       32'sd0},
      '{MODE_SEARCH, 32'sd0,            1'b0, ST_OK,       32'sd0},
      '{MODE_DUMP,   32'sd0,            1'b0, ST_OK,       32'sd0},
      '{MODE_POP,    32'sd0,            1'b1, ST_OK,       32'sh7fff_ffff},
      '{MODE_PUSH,   -32'sd1,           1'b0, ST_OK,       32'sd0},
      '{MODE_PUSH,   32'sd0,            1'b0, ST_OK,       32'sd0},
      '{MODE_PUSH,   32'sd1,            1'b0, ST_OK,       32'sd0},
      '{MODE_PUSH,   32'sh5555_5555,    1'b0, ST_OK,       32'sd0},
      '{MODE_PUSH,   32'shaaaa_aaaa,    1'b0, ST_OK,       32'sd0},
      '{MODE_PUSH,   32'sh1234_5678,    1'b0, ST_OK,       32'sd0},
      '{MODE_PUSH,   32'sh7fff_ffff,    1'b0, ST_OK,       32'sd0},
      '{MODE_PUSH,   32'sd0,            1'b1, ST_OVERFLOW, 32'sd0},
      '{MODE_DUMP,   32'sd0,            1'b0, ST_OK,       32'sd0},
      '{MODE_SEARCH, 32'sh8000_0000,    1'b0, ST_OK,       32'sd0},
      '{MODE_SEARCH, 32'sh0f0f_0f0f,    1'b0, ST_OK,       32'sd0},
      '{MODE_SEARCH, 32'sh7fff_ffff,    1'b0, ST_OK,       32'sd0},
      '{MODE_POP,    32'sd0,            1'b1, ST_OK,       32'sh7fff_ffff},
      '{MODE_POP,    32'sd0,            1'b0, ST_OK,       32'sd0},
      '{MODE_SEARCH, 32'sh1234_5678,    1'b0, ST_OK,       32'sd0}
   };

   task automatic report(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      errors++;
   endtask

   function automatic void predict_stack(input mode_type m, input logic signed [31:0] v);
      beat_type b;
      bit       hit;
      int       i;
      b = '{ST_OK, 32'sd0, 1'b0, 1'b1};
      if (m != MODE_PUSH && stack_fill == 0) begin
         b.status = ST_EMPTY;
         empty_count++;
         pending_beats.push_back(b);
         return;
      end
      case (m)
         MODE_PUSH: begin
            if (stack_fill == DEPTH) begin
               b.status = ST_OVERFLOW;
               overflow_count++;
            end else begin
               stack_words[stack_fill] = v;
               stack_fill++;
            end
            pending_beats.push_back(b);
         end
         MODE_POP: begin
            stack_fill--;
            b.data = stack_words[stack_fill];
            pending_beats.push_back(b);
         end
         MODE_DUMP: begin
            for (i = stack_fill; i > 0; i--) begin
               b.data = stack_words[i-1];
               b.last = (i == 1);
               pending_beats.push_back(b);
            end
         end
         default: begin
            hit = 1'b0;
            for (i = stack_fill; i > 0; i--)
               if (stack_words[i-1] === v) hit = 1'b1;
            b.found = hit;
            pending_beats.push_back(b);
         end
      endcase
      if (stack_fill > peak_fill) peak_fill = stack_fill;
   endfunction

   always @(posedge clock) begin : monitor
      beat_type b;
      if (!reset) begin
         idle_cycles++;
         if (start && !busy) begin
            idle_cycles = 0;
            mode_count[req_mode]++;
            predict_stack(mode_type'(req_mode), req_value);
            if (pin_valid) begin
               void'(pending_beats.pop_back());
               pending_beats.push_back('{pin_status, pin_data, 1'b0, 1'b1});
            end
         end
         if (rsp_strobe) begin
            idle_cycles = 0;
            beats_seen++;
            if (pending_beats.size() == 0) begin
               report("result beat with nothing expected");
            end else begin
               b = pending_beats.pop_front();
               if (rsp_status !== b.status)
                  report($sformatf("beat %0d status %0d, want %0d",
                                   beats_seen, rsp_status, b.status));
               if (rsp_data !== b.data)
                  report($sformatf("beat %0d data %h, want %h", beats_seen, rsp_data, b.data));
               if (rsp_found !== b.found)
                  report($sformatf("beat %0d found %b, want %b",
                                   beats_seen, rsp_found, b.found));
               if (rsp_last !== b.last)
                  report($sformatf("beat %0d last %b, want %b", beats_seen, rsp_last, b.last));
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic send_item(input mode_type m, input logic signed [31:0] v, input bit pin,
                            input status_type ps, input logic signed [31:0] pd);
      int gap;
      if (no_gap_run > 0) begin
         gap = 0;
         no_gap_run--;
      end else begin
         gap = $urandom_range(0, 7);
         if ($urandom_range(0, 19) == 0) no_gap_run = $urandom_range(8, 24);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_mode   <= m;
      req_value  <= v;
      pin_valid  <= pin;
      pin_status <= ps;
      pin_data   <= pd;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_beats.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
         3, 4:    return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   initial begin : stimulus
      bit                 filling;
      int                 r;
      mode_type           m;
      logic signed [31:0] v;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[k])
         send_item(directed[k].mode, directed[k].value, directed[k].pin,
                   directed[k].status, directed[k].data);

      filling = 1'b1;
      for (int k = 0; k < N_RANDOM; k++) begin
         if (k == N_RANDOM / 2) drain();
         if (stack_fill == 0) filling = 1'b1;
         else if (stack_fill == DEPTH && $urandom_range(0, 2) == 0) filling = 1'b0;
         else if ($urandom_range(0, 24) == 0) filling = !filling;
         r = $urandom_range(0, 99);
         if (r < (filling ? 50 : 15)) m = MODE_PUSH;
         else if (r < 62)             m = MODE_POP;
         else if (r < 75)             m = MODE_DUMP;
         else                         m = MODE_SEARCH;
         v = pick_value();
         if (m == MODE_SEARCH && stack_fill > 0 && $urandom_range(0, 1))
            v = stack_words[$urandom_range(0, stack_fill - 1)];
         send_item(m, v, 1'b0, ST_OK, 32'sd0);
      end

      drain();
      repeat (TAIL) @(posedge clock);
      if (pending_beats.size() != 0)
         report($sformatf("%0d result beats never arrived", pending_beats.size()));
      $display("Ran %0d push, %0d pop, %0d dump and %0d search requests; %0d beats checked.",
               mode_count[MODE_PUSH], mode_count[MODE_POP], mode_count[MODE_DUMP],
               mode_count[MODE_SEARCH], beats_seen);
      $display("Peak fill %0d of %0d, %0d overflows, %0d empty-stack answers.",
               peak_fill, DEPTH, overflow_count, empty_count);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* lifo_stack_with_search.f */
hdl/lss_pkg.sv
hdl/lss_ram.sv
hdl/lifo_stack_with_search.sv
hdl/lss_checker.sv
verif/tb_lifo_stack_with_search.sv
